// ===== rtl/core/lfdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfdc_pkg: shared definitions for the line-follow drive controller
// Field widths, register indexes, hold-mode and colour codes, reset values
// and the Q24.8 truncate-toward-zero helper.
// ----------------------------------------------------------------------------
package lfdc_pkg;

   // payload and internal widths
   localparam int ErrWidth      = 11;
   localparam int SumWidth      = 13;
   localparam int DiffWidth     = 14;
   localparam int GainWidth     = 16;
   localparam int RefWidth      = 13;
   localparam int LimitWidth    = 15;
   localparam int TickWidth     = 16;
   localparam int SpeedWidth    = 16;
   localparam int ByteWidth     = 8;
   localparam int ProdEWidth    = SumWidth + GainWidth;
   localparam int ProdDWidth    = DiffWidth + GainWidth;
   localparam int AccWidth      = 32;
   localparam int FracBits      = 8;
   localparam int IntWidth      = AccWidth - FracBits;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 16;

   typedef logic [1:0]                   mode_type;
   typedef logic [1:0]                   colour_type;
   typedef logic signed [SpeedWidth-1:0] speed_type;
   typedef logic signed [IntWidth-1:0]   wide_speed_type;

   // hold modes
   localparam mode_type MODE_FREE    = 2'd0;
   localparam mode_type MODE_STOP    = 2'd1;
   localparam mode_type MODE_RELEASE = 2'd2;
   localparam mode_type MODE_LIGHT   = 2'd3;

   // light colours
   localparam colour_type COLOUR_NONE  = 2'd0;
   localparam colour_type COLOUR_RED   = 2'd1;
   localparam colour_type COLOUR_GREEN = 2'd2;
   localparam colour_type COLOUR_BAD   = 2'd3;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] REG_KP          = 4'd0;
   localparam logic [CsrIndexWidth-1:0] REG_KD          = 4'd1;
   localparam logic [CsrIndexWidth-1:0] REG_REF_LEFT    = 4'd2;
   localparam logic [CsrIndexWidth-1:0] REG_REF_RIGHT   = 4'd3;
   localparam logic [CsrIndexWidth-1:0] REG_LIMIT_HIGH  = 4'd4;
   localparam logic [CsrIndexWidth-1:0] REG_LIMIT_LOW   = 4'd5;
   localparam logic [CsrIndexWidth-1:0] REG_STOP_HOLD   = 4'd6;
   localparam logic [CsrIndexWidth-1:0] REG_LIGHT_HOLD  = 4'd7;

   // reset values
   localparam logic signed [GainWidth-1:0] KP_RESET         = 16'sd128;
   localparam logic signed [GainWidth-1:0] KD_RESET         = 16'sd0;
   localparam logic signed [RefWidth-1:0]  REF_LEFT_RESET   = -13'sd1279;
   localparam logic signed [RefWidth-1:0]  REF_RIGHT_RESET  = 13'sd1000;
   localparam logic [LimitWidth-1:0]       LIMIT_HIGH_RESET = 15'd2600;
   localparam logic [LimitWidth-1:0]       LIMIT_LOW_RESET  = 15'd450;
   localparam logic [TickWidth-1:0]        STOP_HOLD_RESET  = 16'd50;
   localparam logic [TickWidth-1:0]        LIGHT_HOLD_RESET = 16'd20;

   localparam logic [TickWidth-1:0] RELEASE_WAIT_TICKS = 16'd150;
   localparam logic [TickWidth-1:0] TICK_MAX           = 16'hFFFF;

   // Q24.8 to integer, truncating toward zero
   function automatic wide_speed_type q8_trunc(input logic signed [AccWidth-1:0] acc);
      logic signed [AccWidth-1:0] adj;
      adj = acc + (acc[AccWidth-1] ? AccWidth'((1 << FracBits) - 1) : AccWidth'(0));
      return adj[AccWidth-1:FracBits];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/line_follow_drive_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_follow_drive_controller: PD line-following drive with clamp and holds
// A frame word accepted into the input register moves to the product register
// and then to the result register before it shows on rsp_*.
// Throughput: one word per cycle; tick words update the hold timer in the
// input stage and produce no result. The pipeline advances unless rsp_stall
// backs up a full result register and product register.
// Reset: synchronous; clears the pipeline, hold sequencer, light latches and
// previous error; loads the default gains, references, limits and hold times.
// ----------------------------------------------------------------------------
module line_follow_drive_controller (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_action,
   input  wire logic signed [lfdc_pkg::ErrWidth-1:0] req_slice_err0,
   input  wire logic signed [lfdc_pkg::ErrWidth-1:0] req_slice_err1,
   input  wire logic signed [lfdc_pkg::ErrWidth-1:0] req_slice_err2,
   input  wire logic signed [lfdc_pkg::ErrWidth-1:0] req_slice_err3,
   input  wire logic                                 req_stop_seen,
   input  wire logic                                 req_light_seen,
   input  wire logic [1:0]                           req_light_colour,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [lfdc_pkg::SpeedWidth-1:0]    rsp_left_speed,
   output logic signed [lfdc_pkg::SpeedWidth-1:0]    rsp_right_speed,
   output logic signed [lfdc_pkg::SumWidth-1:0]      rsp_error_total,
   output logic [lfdc_pkg::ByteWidth-1:0]            rsp_cmd_byte0,
   output logic [lfdc_pkg::ByteWidth-1:0]            rsp_cmd_byte1,
   output logic [lfdc_pkg::ByteWidth-1:0]            rsp_cmd_byte2,
   output logic [lfdc_pkg::ByteWidth-1:0]            rsp_cmd_byte3,
   output logic [1:0]                                rsp_hold_mode,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lfdc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [lfdc_pkg::CsrDataWidth-1:0]    csr_data
);

   // configuration registers
   logic signed [lfdc_pkg::GainWidth-1:0] kp_ff, kd_ff;
   logic signed [lfdc_pkg::RefWidth-1:0]  ref_left_ff, ref_right_ff;
   logic [lfdc_pkg::LimitWidth-1:0]       limit_high_ff, limit_low_ff;
   logic [lfdc_pkg::TickWidth-1:0]        stop_hold_ff, light_hold_ff;

   // handshake
   logic req_accept, s1_fire, s1_frame, s2_ready, s2_move, out_ready;

   // input stage
   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_action_ff;
   logic signed [lfdc_pkg::ErrWidth-1:0] s1_err0_ff, s1_err1_ff, s1_err2_ff, s1_err3_ff;
   logic                                 s1_stop_ff, s1_light_ff;
   lfdc_pkg::colour_type                 s1_colour_ff;

   // sequencer state
   lfdc_pkg::mode_type                   mode_ff, mode_in;
   logic [lfdc_pkg::TickWidth-1:0]       elapsed_ff, elapsed_in;
   lfdc_pkg::colour_type                 last_light_ff, last_light_in;
   logic                                 red_ff, red_in, green_ff, green_in;
   logic signed [lfdc_pkg::SumWidth-1:0] prev_err_ff, prev_err_in;

   // frame decisions
   lfdc_pkg::mode_type                   mode_n;
   logic [lfdc_pkg::TickWidth-1:0]       elapsed_n;
   lfdc_pkg::colour_type                 colour, last_light_n;
   logic                                 red_n, green_n, force_zero;
   logic signed [lfdc_pkg::SumWidth-1:0]   err_sum;
   logic signed [lfdc_pkg::DiffWidth-1:0]  err_diff;
   logic signed [lfdc_pkg::ProdEWidth-1:0] e_kp_in;
   logic signed [lfdc_pkg::ProdDWidth-1:0] d_kd_in;

   // product stage
   logic                                   s2_valid_ff, s2_valid_in;
   logic signed [lfdc_pkg::ProdEWidth-1:0] s2_e_kp_ff;
   logic signed [lfdc_pkg::ProdDWidth-1:0] s2_d_kd_ff;
   logic signed [lfdc_pkg::SumWidth-1:0]   s2_err_ff;
   lfdc_pkg::mode_type                     s2_mode_ff;
   logic                                   s2_force_ff;

   // clamp
   logic signed [lfdc_pkg::AccWidth-1:0] acc_left, acc_right, pd_sum;
   lfdc_pkg::wide_speed_type             left_raw, right_raw, lim_hi, lim_lo;
   lfdc_pkg::wide_speed_type             left_c1, right_c1, left_c2, right_c2;
   lfdc_pkg::speed_type                  left_in, right_in;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   lfdc_pkg::speed_type                  rsp_left_ff, rsp_right_ff;
   logic signed [lfdc_pkg::SumWidth-1:0] rsp_err_ff;
   lfdc_pkg::mode_type                   rsp_mode_ff;
   logic signed [lfdc_pkg::SpeedWidth:0] neg_left;

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff         <= lfdc_pkg::KP_RESET;
         kd_ff         <= lfdc_pkg::KD_RESET;
         ref_left_ff   <= lfdc_pkg::REF_LEFT_RESET;
         ref_right_ff  <= lfdc_pkg::REF_RIGHT_RESET;
         limit_high_ff <= lfdc_pkg::LIMIT_HIGH_RESET;
         limit_low_ff  <= lfdc_pkg::LIMIT_LOW_RESET;
         stop_hold_ff  <= lfdc_pkg::STOP_HOLD_RESET;
         light_hold_ff <= lfdc_pkg::LIGHT_HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lfdc_pkg::REG_KP:         kp_ff         <= csr_data;
            lfdc_pkg::REG_KD:         kd_ff         <= csr_data;
            lfdc_pkg::REG_REF_LEFT:   ref_left_ff   <= csr_data[lfdc_pkg::RefWidth-1:0];
            lfdc_pkg::REG_REF_RIGHT:  ref_right_ff  <= csr_data[lfdc_pkg::RefWidth-1:0];
            lfdc_pkg::REG_LIMIT_HIGH: limit_high_ff <= csr_data[lfdc_pkg::LimitWidth-1:0];
            lfdc_pkg::REG_LIMIT_LOW:  limit_low_ff  <= csr_data[lfdc_pkg::LimitWidth-1:0];
            lfdc_pkg::REG_STOP_HOLD:  stop_hold_ff  <= csr_data;
            lfdc_pkg::REG_LIGHT_HOLD: light_hold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // flow control
   // ------------------------------------------------------------------
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s2_move    = s2_valid_ff && out_ready;
   assign s1_frame   = s1_valid_ff && s1_action_ff;
   // ticks always drain; frames wait for the product stage
   assign s1_fire    = s1_valid_ff && (!s1_action_ff || s2_ready);
   assign req_stall  = s1_frame && !s2_ready;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
   assign s2_valid_in  = (s1_fire && s1_action_ff) || (s2_valid_ff && !s2_move);
   assign rsp_valid_in = s2_move || (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------
   // input stage
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_action;
         s1_err0_ff   <= req_slice_err0;
         s1_err1_ff   <= req_slice_err1;
         s1_err2_ff   <= req_slice_err2;
         s1_err3_ff   <= req_slice_err3;
         s1_stop_ff   <= req_stop_seen;
         s1_light_ff  <= req_light_seen;
         s1_colour_ff <= req_light_colour;
      end
   end

   // ------------------------------------------------------------------
   // hold sequencer and light latches
   // ------------------------------------------------------------------
   always_comb begin
      colour       = (s1_colour_ff == lfdc_pkg::COLOUR_BAD) ? lfdc_pkg::COLOUR_NONE
                                                            : s1_colour_ff;
      last_light_n = green_ff ? last_light_ff : colour;
      mode_n       = mode_ff;
      elapsed_n    = elapsed_ff;
      red_n        = red_ff;
      green_n      = green_ff;
      force_zero   = 1'b0;

      if (s1_stop_ff && mode_n == lfdc_pkg::MODE_FREE) begin
         elapsed_n = '0;
         mode_n    = lfdc_pkg::MODE_STOP;
      end

      if (mode_n == lfdc_pkg::MODE_STOP) begin
         force_zero = 1'b1;
         if (elapsed_n > stop_hold_ff) mode_n = lfdc_pkg::MODE_RELEASE;
      end else if (mode_n == lfdc_pkg::MODE_RELEASE) begin
         if (elapsed_n > lfdc_pkg::RELEASE_WAIT_TICKS) mode_n = lfdc_pkg::MODE_FREE;
      end

      if (s1_light_ff && !green_ff) begin
         case (mode_n)
            lfdc_pkg::MODE_FREE: begin
               force_zero = 1'b1;
               elapsed_n  = '0;
               mode_n     = lfdc_pkg::MODE_LIGHT;
            end
            lfdc_pkg::MODE_LIGHT: begin
               if (elapsed_n > light_hold_ff) begin
                  if (last_light_n == lfdc_pkg::COLOUR_RED) begin
                     red_n      = 1'b1;
                     force_zero = 1'b1;
                  end else if (last_light_n == lfdc_pkg::COLOUR_GREEN) begin
                     green_n = 1'b1;
                  end
                  mode_n = lfdc_pkg::MODE_FREE;
               end else begin
                  force_zero = 1'b1;
               end
            end
            default: begin
               if (red_ff && last_light_n == lfdc_pkg::COLOUR_GREEN) green_n = 1'b1;
            end
         endcase
      end
   end

   // error sum, derivative and gain products
   assign err_sum  = lfdc_pkg::SumWidth'(s1_err0_ff) + lfdc_pkg::SumWidth'(s1_err1_ff)
                   + lfdc_pkg::SumWidth'(s1_err2_ff) + lfdc_pkg::SumWidth'(s1_err3_ff);
   assign err_diff = lfdc_pkg::DiffWidth'(err_sum) - lfdc_pkg::DiffWidth'(prev_err_ff);
   assign e_kp_in  = lfdc_pkg::ProdEWidth'(err_sum) * lfdc_pkg::ProdEWidth'(kp_ff);
   assign d_kd_in  = lfdc_pkg::ProdDWidth'(err_diff) * lfdc_pkg::ProdDWidth'(kd_ff);

   always_comb begin
      mode_in       = mode_ff;
      elapsed_in    = elapsed_ff;
      last_light_in = last_light_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      prev_err_in   = prev_err_ff;
      if (s1_fire) begin
         if (s1_action_ff) begin
            mode_in       = mode_n;
            elapsed_in    = elapsed_n;
            last_light_in = last_light_n;
            red_in        = red_n;
            green_in      = green_n;
            prev_err_in   = err_sum;
         end else if (elapsed_ff != lfdc_pkg::TICK_MAX) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= lfdc_pkg::MODE_FREE;
         elapsed_ff    <= '0;
         last_light_ff <= lfdc_pkg::COLOUR_NONE;
         red_ff        <= 1'b0;
         green_ff      <= 1'b0;
         prev_err_ff   <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_ff       <= mode_in;
         elapsed_ff    <= elapsed_in;
         last_light_ff <= last_light_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         prev_err_ff   <= prev_err_in;
      end
   end

   // ------------------------------------------------------------------
   // product stage
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_fire && s1_action_ff) begin
         s2_e_kp_ff  <= e_kp_in;
         s2_d_kd_ff  <= d_kd_in;
         s2_err_ff   <= err_sum;
         s2_mode_ff  <= mode_n;
         s2_force_ff <= force_zero;
      end
   end

   // ------------------------------------------------------------------
   // PD sum, truncation and clamps
   // ------------------------------------------------------------------
   assign pd_sum    = lfdc_pkg::AccWidth'(s2_e_kp_ff) + lfdc_pkg::AccWidth'(s2_d_kd_ff);
   assign acc_left  = (lfdc_pkg::AccWidth'(ref_left_ff) <<< lfdc_pkg::FracBits) + pd_sum;
   assign acc_right = (lfdc_pkg::AccWidth'(ref_right_ff) <<< lfdc_pkg::FracBits) + pd_sum;
   assign left_raw  = lfdc_pkg::q8_trunc(acc_left);
   assign right_raw = lfdc_pkg::q8_trunc(acc_right);

   assign lim_hi = lfdc_pkg::wide_speed_type'({1'b0, limit_high_ff});
   assign lim_lo = lfdc_pkg::wide_speed_type'({1'b0, limit_low_ff});

   // high clamp first, then low; left drives forward when negative
   assign right_c1 = (right_raw > lim_hi) ? lim_hi : right_raw;
   assign right_c2 = (right_c1 < lim_lo) ? lim_lo : right_c1;
   assign left_c1  = (left_raw < -lim_hi) ? -lim_hi : left_raw;
   assign left_c2  = (left_c1 > -lim_lo) ? -lim_lo : left_c1;

   assign left_in  = s2_force_ff ? '0 : left_c2[lfdc_pkg::SpeedWidth-1:0];
   assign right_in = s2_force_ff ? '0 : right_c2[lfdc_pkg::SpeedWidth-1:0];

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_left_ff  <= left_in;
         rsp_right_ff <= right_in;
         rsp_err_ff   <= s2_err_ff;
         rsp_mode_ff  <= s2_mode_ff;
      end
   end

   assign neg_left = (lfdc_pkg::SpeedWidth + 1)'(0)
                   - (lfdc_pkg::SpeedWidth + 1)'(rsp_left_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;
   assign rsp_error_total = rsp_err_ff;
   assign rsp_hold_mode   = rsp_mode_ff;
   assign rsp_cmd_byte0   = rsp_right_ff[lfdc_pkg::ByteWidth-1:0];
   assign rsp_cmd_byte1   = rsp_right_ff[2*lfdc_pkg::ByteWidth-1:lfdc_pkg::ByteWidth];
   assign rsp_cmd_byte2   = lfdc_pkg::ByteWidth'(0) - neg_left[lfdc_pkg::ByteWidth-1:0];
   assign rsp_cmd_byte3   = lfdc_pkg::ByteWidth'(0)
                          - neg_left[2*lfdc_pkg::ByteWidth-1:lfdc_pkg::ByteWidth];

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for line_follow_drive_controller
// Drives frame and tick words with bursty timing against a randomly stalling
// receiver and compares every result word with a cycle-free model of the PD
// speed law, the clamps and the stop / traffic-light hold sequencer.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      CYCLE_LIMIT   = 2_000_000;
   localparam int      RESET_CYCLES  = 10;
   localparam int      SETTLE_CYCLES = 8;
   localparam int      REPORT_LIMIT  = 10;
   localparam int      HOLD_OFF_LONG = 400;
   localparam int      PHASE_WORDS   = 55;
   localparam int      TICK_CEILING  = int'(lfdc_pkg::TICK_MAX);
   localparam longint  Q_ONE         = longint'(1) << lfdc_pkg::FracBits;
   localparam logic    ACTION_TICK   = 1'b0;
   localparam logic    ACTION_FRAME  = 1'b1;
   localparam logic [lfdc_pkg::CsrIndexWidth-1:0] REG_SPARE_FIRST =
      lfdc_pkg::REG_LIGHT_HOLD + 1'b1;
   localparam logic [lfdc_pkg::CsrIndexWidth-1:0] REG_SPARE_LAST  = '1;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_style_type;

   typedef struct packed {
      logic                          action;
      logic [lfdc_pkg::ErrWidth-1:0] err0;
      logic [lfdc_pkg::ErrWidth-1:0] err1;
      logic [lfdc_pkg::ErrWidth-1:0] err2;
      logic [lfdc_pkg::ErrWidth-1:0] err3;
      logic                          stop_seen;
      logic                          light_seen;
      lfdc_pkg::colour_type          colour;
   } drive_word_type;

   typedef struct packed {
      lfdc_pkg::speed_type            left;
      lfdc_pkg::speed_type            right;
      logic [lfdc_pkg::SumWidth-1:0]  err_total;
      logic [lfdc_pkg::ByteWidth-1:0] b0;
      logic [lfdc_pkg::ByteWidth-1:0] b1;
      logic [lfdc_pkg::ByteWidth-1:0] b2;
      logic [lfdc_pkg::ByteWidth-1:0] b3;
      lfdc_pkg::mode_type             mode;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                                   req_valid;
   logic                                   req_stall;
   logic                                   req_action;
   logic signed [lfdc_pkg::ErrWidth-1:0]   req_slice_err0;
   logic signed [lfdc_pkg::ErrWidth-1:0]   req_slice_err1;
   logic signed [lfdc_pkg::ErrWidth-1:0]   req_slice_err2;
   logic signed [lfdc_pkg::ErrWidth-1:0]   req_slice_err3;
   logic                                   req_stop_seen;
   logic                                   req_light_seen;
   logic [1:0]                             req_light_colour;

   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic signed [lfdc_pkg::SpeedWidth-1:0] rsp_left_speed;
   logic signed [lfdc_pkg::SpeedWidth-1:0] rsp_right_speed;
   logic signed [lfdc_pkg::SumWidth-1:0]   rsp_error_total;
   logic [lfdc_pkg::ByteWidth-1:0]         rsp_cmd_byte0;
   logic [lfdc_pkg::ByteWidth-1:0]         rsp_cmd_byte1;
   logic [lfdc_pkg::ByteWidth-1:0]         rsp_cmd_byte2;
   logic [lfdc_pkg::ByteWidth-1:0]         rsp_cmd_byte3;
   logic [1:0]                             rsp_hold_mode;

   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [lfdc_pkg::CsrIndexWidth-1:0]     csr_index;
   logic [lfdc_pkg::CsrDataWidth-1:0]      csr_data;

   // model copy of the registers
   int gain_p      = int'(lfdc_pkg::KP_RESET);
   int gain_d      = int'(lfdc_pkg::KD_RESET);
   int base_left   = int'(lfdc_pkg::REF_LEFT_RESET);
   int base_right  = int'(lfdc_pkg::REF_RIGHT_RESET);
   int lim_hi      = int'(lfdc_pkg::LIMIT_HIGH_RESET);
   int lim_lo      = int'(lfdc_pkg::LIMIT_LOW_RESET);
   int stop_ticks  = int'(lfdc_pkg::STOP_HOLD_RESET);
   int light_ticks = int'(lfdc_pkg::LIGHT_HOLD_RESET);

   // model copy of the sequencer and error history
   int                   prev_error    = 0;
   lfdc_pkg::mode_type   hold_mode     = lfdc_pkg::MODE_FREE;
   int                   tick_count    = 0;
   lfdc_pkg::colour_type last_colour   = lfdc_pkg::COLOUR_NONE;
   logic                 red_latched   = 1'b0;
   logic                 green_latched = 1'b0;

   drive_result_type pending_drive[$];

   int              failures     = 0;
   int              cycle_count  = 0;
   int              words_sent   = 0;
   int              burst_left   = 0;
   bit              gaps_on      = 1'b0;
   stall_style_type stall_style  = STALL_NONE;
   int              hold_request = 0;
   int              hold_left    = 0;
   int              stall_phase  = 0;

   line_follow_drive_controller DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slice_err0   (req_slice_err0),
      .req_slice_err1   (req_slice_err1),
      .req_slice_err2   (req_slice_err2),
      .req_slice_err3   (req_slice_err3),
      .req_stop_seen    (req_stop_seen),
      .req_light_seen   (req_light_seen),
      .req_light_colour (req_light_colour),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_speed   (rsp_left_speed),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_error_total  (rsp_error_total),
      .rsp_cmd_byte0    (rsp_cmd_byte0),
      .rsp_cmd_byte1    (rsp_cmd_byte1),
      .rsp_cmd_byte2    (rsp_cmd_byte2),
      .rsp_cmd_byte3    (rsp_cmd_byte3),
      .rsp_hold_mode    (rsp_hold_mode),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------ model

   function automatic longint q8_toward_zero(input longint acc);
      if (acc < 0) return -((-acc) >>> lfdc_pkg::FracBits);
      return acc >>> lfdc_pkg::FracBits;
   endfunction

   function automatic void apply_register(input logic [lfdc_pkg::CsrIndexWidth-1:0] idx,
                                          input logic [lfdc_pkg::CsrDataWidth-1:0] data);
      case (idx)
         lfdc_pkg::REG_KP:         gain_p      = int'($signed(data));
         lfdc_pkg::REG_KD:         gain_d      = int'($signed(data));
         lfdc_pkg::REG_REF_LEFT:
            base_left  = int'($signed(data[lfdc_pkg::RefWidth-1:0]));
         lfdc_pkg::REG_REF_RIGHT:
            base_right = int'($signed(data[lfdc_pkg::RefWidth-1:0]));
         lfdc_pkg::REG_LIMIT_HIGH: lim_hi      = int'(data[lfdc_pkg::LimitWidth-1:0]);
         lfdc_pkg::REG_LIMIT_LOW:  lim_lo      = int'(data[lfdc_pkg::LimitWidth-1:0]);
         lfdc_pkg::REG_STOP_HOLD:  stop_ticks  = int'(data);
         lfdc_pkg::REG_LIGHT_HOLD: light_ticks = int'(data);
         default: ;
      endcase
   endfunction

   function automatic void predict_drive(input drive_word_type w);
      int                   e;
      int                   d;
      longint               left;
      longint               right;
      longint               negl;
      longint               part;
      lfdc_pkg::colour_type colour;
      drive_result_type     r;
      if (w.action == ACTION_TICK) begin
         if (tick_count < TICK_CEILING) tick_count++;
         return;
      end
      colour = (w.colour == lfdc_pkg::COLOUR_BAD) ? lfdc_pkg::COLOUR_NONE : w.colour;
      if (!green_latched) last_colour = colour;

      e = int'($signed(w.err0)) + int'($signed(w.err1)) +
          int'($signed(w.err2)) + int'($signed(w.err3));
      d = e - prev_error;
      prev_error = e;

      left  = q8_toward_zero(longint'(base_left) * Q_ONE + longint'(e) * gain_p +
                             longint'(d) * gain_d);
      right = q8_toward_zero(longint'(base_right) * Q_ONE + longint'(e) * gain_p +
                             longint'(d) * gain_d);
      // high clamp first, low clamp wins when the limits cross
      if (right > lim_hi) right = lim_hi;
      if (left < -lim_hi) left = -lim_hi;
      if (right < lim_lo) right = lim_lo;
      if (left > -lim_lo) left = -lim_lo;

      if (w.stop_seen && hold_mode == lfdc_pkg::MODE_FREE) begin
         tick_count = 0;
         hold_mode  = lfdc_pkg::MODE_STOP;
         left  = 0;
         right = 0;
      end
      if (hold_mode == lfdc_pkg::MODE_STOP) begin
         left  = 0;
         right = 0;
         if (tick_count > stop_ticks) hold_mode = lfdc_pkg::MODE_RELEASE;
      end else if (hold_mode == lfdc_pkg::MODE_RELEASE) begin
         if (tick_count > int'(lfdc_pkg::RELEASE_WAIT_TICKS)) hold_mode = lfdc_pkg::MODE_FREE;
      end

      if (w.light_seen && !green_latched) begin
         if (hold_mode == lfdc_pkg::MODE_FREE) begin
            left       = 0;
            right      = 0;
            tick_count = 0;
            hold_mode  = lfdc_pkg::MODE_LIGHT;
         end else if (hold_mode == lfdc_pkg::MODE_LIGHT) begin
            if (tick_count > light_ticks) begin
               if (last_colour == lfdc_pkg::COLOUR_RED) begin
                  red_latched = 1'b1;
                  left  = 0;
                  right = 0;
               end else if (last_colour == lfdc_pkg::COLOUR_GREEN) begin
                  green_latched = 1'b1;
               end
               hold_mode = lfdc_pkg::MODE_FREE;
            end else begin
               left  = 0;
               right = 0;
            end
         end else if (red_latched && last_colour == lfdc_pkg::COLOUR_GREEN) begin
            green_latched = 1'b1;
         end
      end

      negl        = -left;
      r.left      = left[lfdc_pkg::SpeedWidth-1:0];
      r.right     = right[lfdc_pkg::SpeedWidth-1:0];
      r.err_total = e[lfdc_pkg::SumWidth-1:0];
      r.b0        = right[lfdc_pkg::ByteWidth-1:0];
      part        = right >>> lfdc_pkg::ByteWidth;
      r.b1        = part[lfdc_pkg::ByteWidth-1:0];
      part        = -(negl & longint'(8'hFF));
      r.b2        = part[lfdc_pkg::ByteWidth-1:0];
      part        = -(negl >>> lfdc_pkg::ByteWidth);
      r.b3        = part[lfdc_pkg::ByteWidth-1:0];
      r.mode      = hold_mode;
      pending_drive.push_back(r);
   endfunction

   // --------------------------------------------------------------- checking

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got)
         note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
   endfunction

   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            note_failure("result word with no expectation waiting");
         end else begin
            want = pending_drive.pop_front();
            check_field("left_speed",  longint'(want.left),  longint'(rsp_left_speed));
            check_field("right_speed", longint'(want.right), longint'(rsp_right_speed));
            check_field("error_total", longint'($signed(want.err_total)),
                        longint'(rsp_error_total));
            check_field("cmd_byte0", longint'(want.b0), longint'(rsp_cmd_byte0));
            check_field("cmd_byte1", longint'(want.b1), longint'(rsp_cmd_byte1));
            check_field("cmd_byte2", longint'(want.b2), longint'(rsp_cmd_byte2));
            check_field("cmd_byte3", longint'(want.b3), longint'(rsp_cmd_byte3));
            check_field("hold_mode", longint'(want.mode), longint'(rsp_hold_mode));
         end
      end
   end

   // receiver: long hold-off on request, otherwise the current stall style
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      stall_phase = (stall_phase + 1) % 7;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
            default:      rsp_stall <= (stall_phase < 3);
         endcase
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_word(input drive_word_type w);
      if (gaps_on && burst_left <= 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_action       <= w.action;
      req_slice_err0   <= w.err0;
      req_slice_err1   <= w.err1;
      req_slice_err2   <= w.err2;
      req_slice_err3   <= w.err3;
      req_stop_seen    <= w.stop_seen;
      req_light_seen   <= w.light_seen;
      req_light_colour <= w.colour;
      do @(posedge clock); while (req_stall);
      predict_drive(w);
      burst_left--;
      words_sent++;
   endtask

   // drop valid and let the pipeline empty out
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lfdc_pkg::CsrIndexWidth-1:0] idx,
                            input logic [lfdc_pkg::CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
   endtask

   task automatic configure(input int kp_v, input int kd_v, input int rl_v,
                            input int rr_v, input int lh_v, input int ll_v,
                            input int sh_v, input int lgh_v);
      settle();
      write_reg(lfdc_pkg::REG_KP,         lfdc_pkg::CsrDataWidth'(kp_v));
      write_reg(lfdc_pkg::REG_KD,         lfdc_pkg::CsrDataWidth'(kd_v));
      write_reg(lfdc_pkg::REG_REF_LEFT,   lfdc_pkg::CsrDataWidth'(rl_v));
      write_reg(lfdc_pkg::REG_REF_RIGHT,  lfdc_pkg::CsrDataWidth'(rr_v));
      write_reg(lfdc_pkg::REG_LIMIT_HIGH, lfdc_pkg::CsrDataWidth'(lh_v));
      write_reg(lfdc_pkg::REG_LIMIT_LOW,  lfdc_pkg::CsrDataWidth'(ll_v));
      write_reg(lfdc_pkg::REG_STOP_HOLD,  lfdc_pkg::CsrDataWidth'(sh_v));
      write_reg(lfdc_pkg::REG_LIGHT_HOLD, lfdc_pkg::CsrDataWidth'(lgh_v));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure_defaults(input int sh_v, input int lgh_v);
      configure(int'(lfdc_pkg::KP_RESET), int'(lfdc_pkg::KD_RESET),
                int'(lfdc_pkg::REF_LEFT_RESET), int'(lfdc_pkg::REF_RIGHT_RESET),
                int'(lfdc_pkg::LIMIT_HIGH_RESET), int'(lfdc_pkg::LIMIT_LOW_RESET),
                sh_v, lgh_v);
   endtask

   task automatic configure_random();
      int lh;
      int ll;
      lh = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(600, 4000);
      ll = $urandom_range(0, 1200);
      // upper bits of narrow registers are junk and must be ignored
      configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                lh + 32768 * $urandom_range(0, 1), ll + 32768 * $urandom_range(0, 1),
                $urandom_range(0, 40), $urandom_range(0, 40));
   endtask

   function automatic drive_word_type frame_of(input int e0, input int e1, input int e2,
                                               input int e3, input logic stop,
                                               input logic light,
                                               input lfdc_pkg::colour_type c);
      drive_word_type w;
      w.action     = ACTION_FRAME;
      w.err0       = lfdc_pkg::ErrWidth'(e0);
      w.err1       = lfdc_pkg::ErrWidth'(e1);
      w.err2       = lfdc_pkg::ErrWidth'(e2);
      w.err3       = lfdc_pkg::ErrWidth'(e3);
      w.stop_seen  = stop;
      w.light_seen = light;
      w.colour     = c;
      return w;
   endfunction

   function automatic lfdc_pkg::colour_type random_colour(input bit allow_green);
      lfdc_pkg::colour_type c;
      c = lfdc_pkg::colour_type'($urandom_range(0, 3));
      // hold off green: once latched the light logic goes quiet for good
      if (!allow_green && c == lfdc_pkg::COLOUR_GREEN) c = lfdc_pkg::COLOUR_NONE;
      return c;
   endfunction

   function automatic int random_err();
      if ($urandom_range(0, 1)) return $urandom_range(0, 60) - 30;
      return $urandom_range(0, 2047) - 1024;
   endfunction

   function automatic drive_word_type random_frame(input bit allow_green);
      return frame_of(random_err(), random_err(), random_err(), random_err(),
                      1'b0, 1'b0, random_colour(allow_green));
   endfunction

   task automatic send_ticks(input int n);
      drive_word_type w;
      repeat (n) begin
         w = random_frame(1'b1);
         w.action     = ACTION_TICK;
         w.stop_seen  = 1'($urandom_range(0, 1));
         w.light_seen = 1'($urandom_range(0, 1));
         send_word(w);
      end
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_error_extremes();
      send_word(frame_of(-1024, -1024, -1024, -1024, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(1023, 1023, 1023, 1023, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(0, 0, 0, 0, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(1023, -1024, 5, -3, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
   endtask

   task automatic test_gain_extremes();
      configure(32767, -32768, -4096, 4095, 32767, 0, 50, 20);
      send_word(frame_of(1023, 1023, 1023, 1023, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(-1024, -1024, -1024, -1024, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(1023, 1023, 1023, 1023, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      configure(-32768, 32767, 4095, -4096, 32767, 0, 50, 20);
      send_word(frame_of(-1024, -1024, -1024, -1024, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(1023, 1023, 1023, 1023, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
   endtask

   task automatic test_crossed_limits();
      configure(int'(lfdc_pkg::KP_RESET), int'(lfdc_pkg::KD_RESET),
                int'(lfdc_pkg::REF_LEFT_RESET), int'(lfdc_pkg::REF_RIGHT_RESET),
                100, 3000, 50, 20);
      send_word(frame_of(200, 200, 200, 200, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(-300, -300, -300, -300, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
   endtask

   task automatic test_spare_registers();
      configure_defaults(int'(lfdc_pkg::STOP_HOLD_RESET), int'(lfdc_pkg::LIGHT_HOLD_RESET));
      write_reg(REG_SPARE_FIRST, lfdc_pkg::CsrDataWidth'($urandom_range(0, 65535)));
      write_reg(REG_SPARE_LAST,  lfdc_pkg::CsrDataWidth'($urandom_range(0, 65535)));
      @(negedge clock);
      csr_valid <= 1'b0;
      send_word(frame_of(40, -7, 13, 2, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
   endtask

   task automatic test_stop_hold();
      configure_defaults(2, 3);
      send_word(frame_of(10, 10, 10, 10, 1'b1, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(5, 5, 5, 5, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_ticks(3);
      send_word(frame_of(5, 5, 5, 5, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      // stop sign while releasing is ignored
      send_word(frame_of(-8, 0, 8, 1, 1'b1, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_ticks(148);
      send_word(frame_of(3, 3, 3, 3, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
   endtask

   task automatic test_light_red();
      send_word(frame_of(4, 4, 4, 4, 1'b0, 1'b1, lfdc_pkg::COLOUR_RED));
      send_word(frame_of(4, 4, 4, 4, 1'b0, 1'b1, lfdc_pkg::COLOUR_RED));
      send_ticks(4);
      send_word(frame_of(4, 4, 4, 4, 1'b0, 1'b1, lfdc_pkg::COLOUR_RED));
      // colour code three reads as no colour
      send_word(frame_of(-4, 0, 0, 0, 1'b0, 1'b1, lfdc_pkg::COLOUR_BAD));
      send_ticks(4);
      send_word(frame_of(-4, 0, 0, 0, 1'b0, 1'b1, lfdc_pkg::COLOUR_BAD));
   endtask

   task automatic test_long_hold();
      configure_defaults(TICK_CEILING, 3);
      send_word(frame_of(1, 2, 3, 4, 1'b1, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_ticks(6);
      // full-range hold: still standing after the ticks
      send_word(frame_of(1, 2, 3, 4, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      configure_defaults(0, 3);
      send_word(frame_of(1, 2, 3, 4, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
      send_word(frame_of(1, 2, 3, 4, 1'b0, 1'b0, lfdc_pkg::COLOUR_NONE));
   endtask

   task automatic test_backpressure();
      settle();
      stall_style  = STALL_NONE;
      gaps_on      = 1'b0;
      hold_request = HOLD_OFF_LONG;
      repeat (40) send_word(random_frame(1'b0));
   endtask

   task automatic random_phase(input int n_words, input bit allow_green);
      int             stop_at;
      int             pick;
      int             cap;
      drive_word_type w;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         w = random_frame(allow_green);
         w.stop_seen = ($urandom_range(0, 19) == 0);
         if (pick < 50) begin
            send_word(w);
         end else if (pick < 62) begin
            // stop sign, some of the hold, then part of the release window
            cap = (stop_ticks > 24) ? 24 : stop_ticks;
            w.stop_seen = 1'b1;
            send_word(w);
            send_ticks($urandom_range(0, cap + 4));
            send_word(random_frame(allow_green));
            send_ticks($urandom_range(0, 30));
         end else if (pick < 78) begin
            cap = (light_ticks > 24) ? 24 : light_ticks;
            w.light_seen = 1'b1;
            send_word(w);
            send_ticks($urandom_range(0, cap + 4));
            w = random_frame(allow_green);
            w.light_seen = 1'b1;
            send_word(w);
         end else if (pick < 90) begin
            send_ticks($urandom_range(1, 12));
         end else begin
            w.action     = 1'($urandom_range(0, 1));
            w.stop_seen  = 1'($urandom_range(0, 1));
            w.light_seen = 1'($urandom_range(0, 1));
            send_word(w);
         end
      end
   endtask

   task automatic test_random_traffic();
      stall_style = STALL_RANDOM;
      gaps_on     = 1'b1;
      configure_defaults(int'(lfdc_pkg::STOP_HOLD_RESET), int'(lfdc_pkg::LIGHT_HOLD_RESET));
      random_phase(PHASE_WORDS, 1'b0);

      stall_style = STALL_PATTERN;
      configure(32767, -32768, -4096, 4095, 32767, 0, 0, 0);
      random_phase(PHASE_WORDS, 1'b0);

      stall_style = STALL_NONE;
      gaps_on     = 1'b0;
      configure(-32768, 32767, 4095, -4096, 0, 32767, 1, 1);
      random_phase(PHASE_WORDS, 1'b0);

      stall_style = STALL_RANDOM;
      gaps_on     = 1'b1;
      configure_random();
      random_phase(PHASE_WORDS, 1'b0);

      stall_style = STALL_PATTERN;
      configure_random();
      random_phase(PHASE_WORDS, 1'b0);

      stall_style = STALL_RANDOM;
      configure_random();
      random_phase(PHASE_WORDS, 1'b1);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACTION_TICK;
      req_slice_err0   = '0;
      req_slice_err1   = '0;
      req_slice_err2   = '0;
      req_slice_err3   = '0;
      req_stop_seen    = 1'b0;
      req_light_seen   = 1'b0;
      req_light_colour = lfdc_pkg::COLOUR_NONE;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = lfdc_pkg::REG_KP;
      csr_data         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      stall_style = STALL_RANDOM;
      gaps_on     = 1'b1;
      test_error_extremes();
      test_gain_extremes();
      test_crossed_limits();
      test_spare_registers();
      test_stop_hold();
      test_light_red();
      test_long_hold();
      test_backpressure();
      test_random_traffic();

      settle();
      if (pending_drive.size() != 0)
         note_failure($sformatf("%0d expected words never arrived", pending_drive.size()));
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/lfdc_pkg.sv
rtl/core/line_follow_drive_controller.sv
tb/testbench.sv
